### hw/rtl/imubd_pkg.sv
package imubd_pkg;

   // Byte stream and record widths
   localparam int BYTE_W   = 8;
   localparam int WORD32_W = 32;
   localparam int WORD64_W = 64;
   localparam int POS_W    = 6;

   // Frame layout
   localparam int BODY_LEN  = 46;
   localparam int BODY_SKIP = 6;                       // receiver week and ms, dropped
   localparam int LAST_TAP  = BODY_LEN - 2;            // last body byte held in the shift line
   localparam int TAP_DEPTH = BODY_LEN - 1 - BODY_SKIP; // bytes 6..44

   localparam logic [POS_W-1:0] BODY_LAST_POS = POS_W'(BODY_LEN - 1);
   localparam logic [POS_W-1:0] HEAD_LEN_POS  = POS_W'(0);
   localparam logic [POS_W-1:0] HEAD_IDLO_POS = POS_W'(1);
   localparam logic [POS_W-1:0] HEAD_IDHI_POS = POS_W'(2);

   localparam logic [23:0] SYNC_PATTERN = 24'hAA4413;
   localparam logic [15:0] ID_SHORT     = 16'd325;
   localparam logic [15:0] ID_LONG      = 16'd1462;

   localparam logic KIND_SHORT = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

endpackage

### hw/rtl/imubd_req_if.sv
interface imubd_req_if;
   import imubd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);

endinterface

### hw/rtl/imubd_rsp_if.sv
interface imubd_rsp_if;
   import imubd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       msg_kind;
   logic [BYTE_W-1:0]          imu_info;
   logic [BYTE_W-1:0]          imu_type;
   logic [WORD32_W-1:0]        gnss_week;
   logic [WORD64_W-1:0]        gnss_seconds_bits;
   logic [WORD32_W-1:0]        imu_status;
   logic signed [WORD32_W-1:0] accel_z;
   logic signed [WORD32_W-1:0] accel_neg_y;
   logic signed [WORD32_W-1:0] accel_x;
   logic signed [WORD32_W-1:0] gyro_z;
   logic signed [WORD32_W-1:0] gyro_neg_y;
   logic signed [WORD32_W-1:0] gyro_x;

   modport source (
      output valid, output msg_kind, output imu_info, output imu_type,
      output gnss_week, output gnss_seconds_bits, output imu_status,
      output accel_z, output accel_neg_y, output accel_x,
      output gyro_z, output gyro_neg_y, output gyro_x,
      input  ready
   );
   modport sink (
      input  valid, input msg_kind, input imu_info, input imu_type,
      input  gnss_week, input gnss_seconds_bits, input imu_status,
      input  accel_z, input accel_neg_y, input accel_x,
      input  gyro_z, input gyro_neg_y, input gyro_x,
      output ready
   );

endinterface

### hw/rtl/imu_binary_log_deframer_core.sv
// Raw IMU binary log deframer.
// req_ch takes one log byte per word. The core hunts for the sync bytes
// AA 44 13, skips the header length byte, reads the little-endian message ID
// and, for ID 325 (short) or ID 1462 (extended), collects the 46-byte body.
// rsp_ch then carries one record of raw IMU fields; other IDs and all
// non-body bytes produce nothing.
// Throughput: one byte per cycle while req_ch.ready is high, set by the single
// compare-and-shift pass between the byte input and the record register.
// The record appears on rsp_ch in the cycle after the last body byte
// is accepted.
// Stalls: one output register decouples the channels. req_ch.ready stays
// high while that register is empty or being drained, so bytes keep flowing
// while a record is taken; req_ch.ready drops only while a record is held and
// rsp_ch.ready is low.
// Reset (synchronous, active high): back to hunting with a cleared sync
// window and no record pending; usable on the next cycle.
module imu_binary_log_deframer_core (
   input  logic        clock,
   input  logic        reset,
   imubd_req_if.sink   req_ch,
   imubd_rsp_if.source rsp_ch
);
   import imubd_pkg::*;

   // Control state
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [23:0]        sync_ff, sync_in;
   logic [BYTE_W-1:0]  id_lo_ff, id_lo_in;
   logic               kind_ff, kind_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Body shift line, newest byte at tap 0
   logic [BYTE_W-1:0]  body_sh_ff [TAP_DEPTH];
   logic [BYTE_W-1:0]  body_sh_in [TAP_DEPTH];
   logic [BYTE_W-1:0]  bb [BODY_SKIP:BODY_LEN-1];

   // Record register
   logic                       kind_out_ff;
   logic [BYTE_W-1:0]          info_ff, type_ff;
   logic [WORD32_W-1:0]        week_ff, status_ff;
   logic [WORD64_W-1:0]        secs_ff;
   logic signed [WORD32_W-1:0] az_ff, ay_ff, ax_ff, gz_ff, gy_ff, gx_ff;

   logic               accept;
   logic [BYTE_W-1:0]  in_b;
   logic [23:0]        sync_shift;
   logic [15:0]        id_full;
   logic               id_known;
   logic               body_done;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_b         = req_ch.in_byte;
   assign sync_shift   = {sync_ff[15:0], in_b};
   assign id_full      = {in_b, id_lo_ff};
   assign id_known     = (id_full == ID_SHORT) || (id_full == ID_LONG);
   assign body_done    = accept && (phase_ff == PH_BODY) && (pos_ff == BODY_LAST_POS);

   // Map body byte numbers onto shift line taps; the last byte is the live input
   for (genvar k = BODY_SKIP; k < BODY_LEN - 1; k++) begin : g_taps
      assign bb[k] = body_sh_ff[LAST_TAP - k];
   end
   assign bb[BODY_LEN-1] = in_b;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HEAD: begin
               if (pos_ff == HEAD_IDHI_POS) begin
                  phase_in = id_known ? PH_BODY : PH_HUNT;
               end
            end
            PH_BODY: begin
               if (pos_ff == BODY_LAST_POS) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = (sync_shift == SYNC_PATTERN) ? PH_HEAD : PH_HUNT;
            end
         endcase
      end
   end

   // Position, window, ID and body capture
   always_comb begin
      pos_in     = pos_ff;
      sync_in    = sync_ff;
      id_lo_in   = id_lo_ff;
      kind_in    = kind_ff;
      body_sh_in = body_sh_ff;
      if (accept) begin
         case (phase_ff)
            PH_HEAD: begin
               if (pos_ff == HEAD_LEN_POS) begin
                  pos_in = HEAD_IDLO_POS;
               end else if (pos_ff == HEAD_IDLO_POS) begin
                  id_lo_in = in_b;
                  pos_in   = HEAD_IDHI_POS;
               end else begin
                  pos_in = '0;
                  if (id_full == ID_SHORT) begin
                     kind_in = KIND_SHORT;
                  end else if (id_full == ID_LONG) begin
                     kind_in = KIND_LONG;
                  end
               end
            end
            PH_BODY: begin
               pos_in        = (pos_ff == BODY_LAST_POS) ? '0 : pos_ff + POS_W'(1);
               body_sh_in[0] = in_b;
               for (int i = 1; i < TAP_DEPTH; i++) begin
                  body_sh_in[i] = body_sh_ff[i-1];
               end
            end
            default: begin
               sync_in = sync_shift;
               pos_in  = '0;
            end
         endcase
      end
   end

   // Output valid: set on a finished body, clear once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (body_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         pos_ff       <= '0;
         sync_ff      <= '0;
         id_lo_ff     <= '0;
         kind_ff      <= KIND_SHORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         sync_ff      <= sync_in;
         id_lo_ff     <= id_lo_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      body_sh_ff <= body_sh_in;
   end

   // Load the record register on the last body byte
   always_ff @(posedge clock) begin
      if (body_done) begin
         kind_out_ff <= kind_ff;
         if (kind_ff == KIND_LONG) begin
            info_ff <= bb[6];
            type_ff <= bb[7];
            week_ff <= {16'h0000, bb[9], bb[8]};
         end else begin
            info_ff <= '0;
            type_ff <= '0;
            week_ff <= {bb[9], bb[8], bb[7], bb[6]};
         end
         secs_ff   <= {bb[17], bb[16], bb[15], bb[14], bb[13], bb[12], bb[11], bb[10]};
         status_ff <= {bb[21], bb[20], bb[19], bb[18]};
         az_ff     <= {bb[25], bb[24], bb[23], bb[22]};
         ay_ff     <= {bb[29], bb[28], bb[27], bb[26]};
         ax_ff     <= {bb[33], bb[32], bb[31], bb[30]};
         gz_ff     <= {bb[37], bb[36], bb[35], bb[34]};
         gy_ff     <= {bb[41], bb[40], bb[39], bb[38]};
         gx_ff     <= {bb[45], bb[44], bb[43], bb[42]};
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.msg_kind          = kind_out_ff;
   assign rsp_ch.imu_info          = info_ff;
   assign rsp_ch.imu_type          = type_ff;
   assign rsp_ch.gnss_week         = week_ff;
   assign rsp_ch.gnss_seconds_bits = secs_ff;
   assign rsp_ch.imu_status        = status_ff;
   assign rsp_ch.accel_z           = az_ff;
   assign rsp_ch.accel_neg_y       = ay_ff;
   assign rsp_ch.accel_x           = ax_ff;
   assign rsp_ch.gyro_z            = gz_ff;
   assign rsp_ch.gyro_neg_y        = gy_ff;
   assign rsp_ch.gyro_x            = gx_ff;

`ifndef SYNTHESIS
   // Position stays inside the frame region of each phase
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff != PH_HEAD) || (pos_ff <= HEAD_IDHI_POS)) &&
      ((phase_ff != PH_BODY) || (pos_ff <= BODY_LAST_POS)) &&
      ((phase_ff != PH_HUNT) || (pos_ff == '0)))
      else $error("byte position out of range for phase");

   // Header is entered only with the sync pattern in the window
   a_head_sync: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEAD) |-> (sync_ff == SYNC_PATTERN))
      else $error("header phase without sync pattern");

   // A record appears only after the last body byte
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(phase_ff) == PH_BODY) && ($past(pos_ff) == BODY_LAST_POS))
      else $error("record raised outside body completion");

   // A finished body always leaves the parser hunting with a record pending
   a_done_hunt: assert property (@(posedge clock) disable iff (reset)
      body_done |=> (phase_ff == PH_HUNT) && rsp_valid_ff)
      else $error("body completion did not return to hunting");
`endif

endmodule

### dv/imubd_record_checker.sv
module imubd_record_checker (
   input  logic        clock,
   input  logic        reset,
   imubd_req_if        req_mon,
   imubd_rsp_if        rsp_mon,
   output int unsigned error_count,
   output int unsigned records_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import imubd_pkg::*;

   typedef struct packed {
      logic                       msg_kind;
      logic [BYTE_W-1:0]          imu_info;
      logic [BYTE_W-1:0]          imu_type;
      logic [WORD32_W-1:0]        gnss_week;
      logic [WORD64_W-1:0]        gnss_seconds_bits;
      logic [WORD32_W-1:0]        imu_status;
      logic signed [WORD32_W-1:0] accel_z;
      logic signed [WORD32_W-1:0] accel_neg_y;
      logic signed [WORD32_W-1:0] accel_x;
      logic signed [WORD32_W-1:0] gyro_z;
      logic signed [WORD32_W-1:0] gyro_neg_y;
      logic signed [WORD32_W-1:0] gyro_x;
   } imu_record_type;

   // Framing state of the predicted deframer
   logic [23:0]       sync_window;
   phase_type         phase;
   logic [POS_W-1:0]  position;
   logic [15:0]       message_id;
   logic              record_kind;
   logic [BYTE_W-1:0] body_bytes [BODY_LEN];

   imu_record_type    record_q [$];

   initial error_count = 0;

   // Assemble a little-endian value from the collected body
   function automatic logic [63:0] body_le(input int at, input int count);
      logic [63:0] value;
      value = '0;
      for (int k = count - 1; k >= 0; k--) begin
         value = {value[55:0], body_bytes[at + k]};
      end
      return value;
   endfunction

   // Advance the framing state by one accepted byte; queue a record at body end
   task automatic deframe_byte(input logic [BYTE_W-1:0] value);
      imu_record_type rec;
      case (phase)
         PH_HEAD: begin
            if (position == HEAD_LEN_POS) begin
               position = HEAD_IDLO_POS;
            end else if (position == HEAD_IDLO_POS) begin
               message_id = {8'h00, value};
               position   = HEAD_IDHI_POS;
            end else begin
               message_id = {value, message_id[7:0]};
               position   = '0;
               if (message_id == ID_SHORT) begin
                  record_kind = KIND_SHORT;
                  phase       = PH_BODY;
               end else if (message_id == ID_LONG) begin
                  record_kind = KIND_LONG;
                  phase       = PH_BODY;
               end else begin
                  phase = PH_HUNT;
               end
            end
         end
         PH_BODY: begin
            body_bytes[position] = value;
            if (position != BODY_LAST_POS) begin
               position = position + 1'b1;
            end else begin
               position     = '0;
               phase        = PH_HUNT;
               rec.msg_kind = record_kind;
               if (record_kind == KIND_LONG) begin
                  rec.imu_info  = body_bytes[6];
                  rec.imu_type  = body_bytes[7];
                  rec.gnss_week = 32'(body_le(8, 2));
               end else begin
                  rec.imu_info  = '0;
                  rec.imu_type  = '0;
                  rec.gnss_week = 32'(body_le(6, 4));
               end
               rec.gnss_seconds_bits = body_le(10, 8);
               rec.imu_status        = 32'(body_le(18, 4));
               rec.accel_z           = 32'(body_le(22, 4));
               rec.accel_neg_y       = 32'(body_le(26, 4));
               rec.accel_x           = 32'(body_le(30, 4));
               rec.gyro_z            = 32'(body_le(34, 4));
               rec.gyro_neg_y        = 32'(body_le(38, 4));
               rec.gyro_x            = 32'(body_le(42, 4));
               record_q.push_back(rec);
            end
         end
         default: begin
            // hunt: shift the window only here, so framing keeps the pattern
            phase       = PH_HUNT;
            sync_window = {sync_window[15:0], value};
            if (sync_window == SYNC_PATTERN) begin
               phase    = PH_HEAD;
               position = '0;
            end
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Match one delivered record against the oldest expected one
   task automatic check_record();
      imu_record_type want;
      if (record_q.size() == 0) begin
         $display("%0t: unexpected record: expected none, actual kind %0d status %h",
                  $time, rsp_mon.msg_kind, rsp_mon.imu_status);
         error_count++;
      end else begin
         want = record_q.pop_front();
         compare_field("msg_kind", 64'(want.msg_kind), 64'(rsp_mon.msg_kind));
         compare_field("imu_info", 64'(want.imu_info), 64'(rsp_mon.imu_info));
         compare_field("imu_type", 64'(want.imu_type), 64'(rsp_mon.imu_type));
         compare_field("gnss_week", 64'(want.gnss_week), 64'(rsp_mon.gnss_week));
         compare_field("gnss_seconds_bits", want.gnss_seconds_bits,
                       rsp_mon.gnss_seconds_bits);
         compare_field("imu_status", 64'(want.imu_status), 64'(rsp_mon.imu_status));
         compare_field("accel_z", 64'($unsigned(want.accel_z)),
                       64'($unsigned(rsp_mon.accel_z)));
         compare_field("accel_neg_y", 64'($unsigned(want.accel_neg_y)),
                       64'($unsigned(rsp_mon.accel_neg_y)));
         compare_field("accel_x", 64'($unsigned(want.accel_x)),
                       64'($unsigned(rsp_mon.accel_x)));
         compare_field("gyro_z", 64'($unsigned(want.gyro_z)),
                       64'($unsigned(rsp_mon.gyro_z)));
         compare_field("gyro_neg_y", 64'($unsigned(want.gyro_neg_y)),
                       64'($unsigned(rsp_mon.gyro_neg_y)));
         compare_field("gyro_x", 64'($unsigned(want.gyro_x)),
                       64'($unsigned(rsp_mon.gyro_x)));
      end
   endtask

   // Watch both channels; bytes first, then records
   always @(posedge clock) begin
      if (reset) begin
         sync_window = '0;
         phase       = PH_HUNT;
         position    = '0;
         message_id  = '0;
         record_kind = KIND_SHORT;
         record_q.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            deframe_byte(req_mon.in_byte);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            check_record();
         end
      end
      records_pending <= record_q.size();
   end

endmodule

### dv/tb_imu_binary_log_deframer_core.sv
module tb_imu_binary_log_deframer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import imubd_pkg::*;

   localparam int unsigned RESET_CYCLES      = 6;
   localparam int unsigned RANDOM_BYTES      = 1400;
   localparam int unsigned HOLD_AT_RECORDS   = 10;
   localparam int unsigned PAUSE_AT_RECORDS  = 18;
   localparam int unsigned LONG_HOLD_CYCLES  = 400;
   localparam int unsigned SETTLE_CYCLES     = 20;
   localparam int unsigned CYCLE_LIMIT       = 200000;
   localparam logic [7:0]  SYNC_A            = SYNC_PATTERN[23:16];
   localparam logic [7:0]  SYNC_B            = SYNC_PATTERN[15:8];
   localparam logic [7:0]  SYNC_C            = SYNC_PATTERN[7:0];

   typedef enum {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_EDGY,
      FILL_SIGNED_LOW,
      FILL_SIGNED_HIGH
   } body_fill_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned error_count;
   int unsigned records_pending;
   int unsigned cycle_count;
   int unsigned bytes_sent = 0;
   int unsigned records_sent = 0;
   bit          sender_gaps_on = 1'b0;
   bit          quiet_tail = 1'b0;
   bit          hold_request = 1'b0;
   logic [7:0]  frame_body [BODY_LEN];

   imubd_req_if req_ch ();
   imubd_rsp_if rsp_ch ();

   imu_binary_log_deframer_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   imubd_record_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .error_count     (error_count),
      .records_pending (records_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Bound the run
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Fill the next message body
   function automatic void fill_body(input body_fill_type style);
      int unsigned word_idx, lane;
      bit          take_min;
      for (int i = 0; i < BODY_LEN; i++) begin
         case (style)
            FILL_ZERO: frame_body[i] = 8'h00;
            FILL_ONES: frame_body[i] = 8'hFF;
            FILL_EDGY: begin
               case ($urandom_range(0, 5))
                  0:       frame_body[i] = 8'h00;
                  1:       frame_body[i] = 8'hFF;
                  2:       frame_body[i] = 8'h80;
                  3:       frame_body[i] = 8'h7F;
                  4:       frame_body[i] = 8'h01;
                  default: frame_body[i] = 8'($urandom);
               endcase
            end
            FILL_SIGNED_LOW, FILL_SIGNED_HIGH: begin
               // alternate the sensor words between most negative and most positive
               if (i < 22) begin
                  frame_body[i] = 8'($urandom);
               end else begin
                  word_idx = (i - 22) / 4;
                  lane     = (i - 22) % 4;
                  take_min = ((word_idx % 2) == 0) == (style == FILL_SIGNED_LOW);
                  if (take_min) frame_body[i] = (lane == 3) ? 8'h80 : 8'h00;
                  else          frame_body[i] = (lane == 3) ? 8'h7F : 8'hFF;
               end
            end
            default: frame_body[i] = 8'($urandom);
         endcase
      end
   endfunction

   // Offer one word, with an occasional idle burst ahead of it
   task automatic send_byte(input logic [7:0] value);
      if (sender_gaps_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_ch.valid   <= 1'b0;
         req_ch.in_byte <= 8'($urandom);
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [7:0] len, input logic [15:0] id);
      send_byte(SYNC_A);
      send_byte(SYNC_B);
      send_byte(SYNC_C);
      send_byte(len);
      send_byte(id[7:0]);
      send_byte(id[15:8]);
   endtask

   task automatic send_frame(input logic kind, input logic [7:0] len);
      send_header(len, (kind == KIND_LONG) ? ID_LONG : ID_SHORT);
      for (int i = 0; i < BODY_LEN; i++) begin
         send_byte(frame_body[i]);
      end
      records_sent++;
   endtask

   // Stop offering and hold until every expected record has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (records_pending != 0);
   endtask

   // Drain records, with stall bursts and one long hold-off on request
   initial begin : record_sink
      int unsigned window_left;
      bit          gaps_on;
      window_left = 0;
      gaps_on     = 1'b0;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (window_left == 0) begin
            gaps_on     = ($urandom_range(0, 2) != 0);
            window_left = 100;
         end
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         window_left--;
      end
   end

   // Byte stream: directed framing cases, then random traffic
   initial begin : byte_source
      int unsigned pick;
      int unsigned count;
      bit          hold_done;
      bit          pause_done;
      logic [15:0] odd_id;
      logic [7:0]  tail;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // doubled lead byte ahead of the sync
      send_byte(SYNC_A);
      fill_body(FILL_ZERO);
      send_frame(KIND_SHORT, 8'h00);
      fill_body(FILL_ONES);
      send_frame(KIND_LONG, 8'hFF);
      fill_body(FILL_SIGNED_LOW);
      send_frame(KIND_SHORT, 8'h2C);
      fill_body(FILL_SIGNED_HIGH);
      send_frame(KIND_LONG, 8'h2C);

      // rejected IDs: byte-swapped, one bit off the extended ID, all ones
      send_header(8'h2C, {ID_SHORT[7:0], ID_SHORT[15:8]});
      send_header(8'h2C, ID_LONG ^ 16'h0100);
      send_header(8'h00, 16'hFFFF);

      // rejected header with length AA and ID low byte 44, then 13 must not resync
      send_header(SYNC_A, {8'h00, SYNC_B});
      send_byte(SYNC_C);

      // body ending in AA 44, then 13 must not resync either
      fill_body(FILL_RANDOM);
      frame_body[BODY_LEN-2] = SYNC_A;
      frame_body[BODY_LEN-1] = SYNC_B;
      send_frame(KIND_LONG, 8'h58);
      send_byte(SYNC_C);

      // sync pattern inside a body is plain data
      fill_body(FILL_EDGY);
      frame_body[20] = SYNC_A;
      frame_body[21] = SYNC_B;
      frame_body[22] = SYNC_C;
      send_frame(KIND_SHORT, 8'h2C);
      fill_body(FILL_ONES);
      send_frame(KIND_SHORT, 8'h2C);
      fill_body(FILL_ZERO);
      send_frame(KIND_LONG, 8'h2C);

      while (bytes_sent < RANDOM_BYTES) begin
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         quiet_tail     = (bytes_sent + 250 >= RANDOM_BYTES);
         if (!hold_done && records_sent >= HOLD_AT_RECORDS) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (!pause_done && records_sent >= PAUSE_AT_RECORDS) begin
            wait_drained();
            pause_done = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            fill_body((pick < 8) ? FILL_RANDOM : FILL_EDGY);
            send_frame(1'($urandom_range(0, 1)), 8'($urandom));
         end else if (pick < 16) begin
            // line noise
            count = $urandom_range(1, 8);
            repeat (count) send_byte(8'($urandom));
         end else if (pick < 18) begin
            // unknown ID, sometimes one bit away from a known one
            odd_id = 16'($urandom);
            if (pick == 17) begin
               odd_id = ($urandom_range(0, 1) != 0) ? ID_SHORT : ID_LONG;
               odd_id = odd_id ^ (16'h0001 << $urandom_range(0, 15));
            end
            if (odd_id == ID_SHORT || odd_id == ID_LONG) odd_id = ~odd_id;
            send_header(8'($urandom), odd_id);
         end else if (pick == 18) begin
            // broken sync
            tail = 8'($urandom);
            if (tail == SYNC_C) tail = ~tail;
            send_byte(SYNC_A);
            if ($urandom_range(0, 1) != 0) begin
               send_byte(SYNC_B);
               send_byte(tail);
            end else begin
               send_byte(tail);
               send_byte(SYNC_C);
            end
         end else begin
            // truncated message: the stream that follows completes its body
            send_header(8'($urandom), ($urandom_range(0, 1) != 0) ? ID_SHORT : ID_LONG);
            count = $urandom_range(1, BODY_LEN - 1);
            repeat (count) send_byte(8'($urandom));
            records_sent++;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && records_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/imubd_pkg.sv
hw/rtl/imubd_req_if.sv
hw/rtl/imubd_rsp_if.sv
hw/rtl/imu_binary_log_deframer_core.sv
dv/imubd_record_checker.sv
dv/tb_imu_binary_log_deframer_core.sv
